>>> rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, codes and defaults for the slotted page store.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int SLOT_LIMIT_DEF   = 1024;
    localparam int HEADER_BYTES     = 6;
    localparam int SLOT_ENTRY_BYTES = 4;

    // insert byte counter saturates here and flags an over-long run
    localparam int CNT_W     = 13;
    localparam int COUNT_MAX = 8191;

    typedef logic [2:0]  status_t;
    typedef logic [12:0] length_t;
    typedef logic [7:0]  byte_t;
    typedef logic [9:0]  slot_t;
    typedef logic [11:0] index_t;
    typedef logic [10:0] used_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_NO_SPACE = 3'd1;
    localparam status_t ST_EMPTY    = 3'd2;
    localparam status_t ST_MISMATCH = 3'd3;
    localparam status_t ST_BAD_SLOT = 3'd4;
    localparam status_t ST_BEYOND   = 3'd5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef struct packed {
        logic    action;
        length_t record_length;
        byte_t   data_byte;
        logic    last_byte;
        slot_t   slot_id;
        index_t  byte_index;
    } req_t;

    typedef struct packed {
        status_t status;
        byte_t   read_byte;
        length_t record_size;
        slot_t   new_slot;
        used_t   slots_used;
        length_t free_offset;
    } rsp_t;

    // insert tracker to top level
    typedef struct packed {
        logic    page_we;
        logic    commit;
        status_t status;
    } ins_ctl_t;

endpackage

>>> rtl/spc_ram.sv
// ----------------------------------------------------------------------------
// spc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/spc_insert.sv
// ----------------------------------------------------------------------------
// spc_insert
// Insert run tracker: space check on the first byte, byte count, page write
// address and the commit decision on the last byte.
// ----------------------------------------------------------------------------
module spc_insert #(
    parameter int PAGE_BYTES = spc_pkg::PAGE_BYTES_DEF,
    parameter int SLOT_LIMIT = spc_pkg::SLOT_LIMIT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_valid,
    input  spc_pkg::length_t         rec_len,
    input  logic                     last_byte,
    input  logic [$clog2(SLOT_LIMIT+1)-1:0] slot_total,
    input  logic [$clog2(PAGE_BYTES+1)-1:0] free_ptr,
    input  logic [$clog2(spc_pkg::HEADER_BYTES
                   + spc_pkg::SLOT_ENTRY_BYTES * SLOT_LIMIT + 1)-1:0] dir_end,
    output spc_pkg::ins_ctl_t        ctl,
    output logic [$clog2(PAGE_BYTES)-1:0]   page_waddr,
    output logic [$clog2(PAGE_BYTES)-1:0]   rec_base,
    output logic [$clog2(PAGE_BYTES+1)-1:0] rec_size
);

    localparam int PAW  = $clog2(PAGE_BYTES);
    localparam int PW   = $clog2(PAGE_BYTES + 1);
    localparam int SCW  = $clog2(SLOT_LIMIT + 1);
    localparam int DW   = $clog2(spc_pkg::HEADER_BYTES
                                 + spc_pkg::SLOT_ENTRY_BYTES * SLOT_LIMIT + 1);
    localparam int CHKW = ((DW > spc_pkg::CNT_W) ? DW : spc_pkg::CNT_W) + 2;
    localparam int WW   = ((PW > spc_pkg::CNT_W) ? PW : spc_pkg::CNT_W) + 1;

    logic [spc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;
    spc_pkg::status_t          rej_reg, rej_next;
    logic [PAW-1:0]            base_reg, base_next;
    logic [PW-1:0]             len_reg, len_next;

    logic                      first;
    logic                      full;
    logic                      no_space;
    logic [CHKW-1:0]           need;
    spc_pkg::status_t          rej_now;
    logic [PW-1:0]             want;
    logic [spc_pkg::CNT_W-1:0] cnt_inc;
    logic                      ovf_inc;
    logic                      mismatch;
    spc_pkg::status_t          final_st;
    logic [WW-1:0]             waddr_full;

    always_comb
    begin
        first    = (cnt_reg == '0) && !ovf_reg;
        full     = (slot_total == SCW'(SLOT_LIMIT));
        need     = CHKW'(dir_end) + CHKW'(rec_len) + CHKW'(spc_pkg::SLOT_ENTRY_BYTES);
        no_space = (CHKW'(free_ptr) < need);

        if (!first)
        begin
            rej_now = rej_reg;
        end
        else if (rec_len == '0)
        begin
            rej_now = spc_pkg::ST_EMPTY;
        end
        else if (full || no_space)
        begin
            rej_now = spc_pkg::ST_NO_SPACE;
        end
        else
        begin
            rej_now = spc_pkg::ST_OK;
        end

        // rec_len is below free_ptr whenever it is accepted
        if (first && rej_now == spc_pkg::ST_OK)
        begin
            base_next = PAW'(free_ptr - PW'(rec_len));
            len_next  = PW'(rec_len);
        end
        else
        begin
            base_next = base_reg;
            len_next  = len_reg;
        end

        want = (rej_now == spc_pkg::ST_OK) ? len_next : '0;

        ovf_inc = ovf_reg || (cnt_reg == spc_pkg::CNT_W'(spc_pkg::COUNT_MAX));
        cnt_inc = (cnt_reg == spc_pkg::CNT_W'(spc_pkg::COUNT_MAX))
                  ? cnt_reg : cnt_reg + 1'b1;

        mismatch = (rej_now == spc_pkg::ST_OK)
                   && (ovf_inc || (WW'(cnt_inc) != WW'(want)));
        if (rej_now != spc_pkg::ST_OK)
        begin
            final_st = rej_now;
        end
        else if (mismatch)
        begin
            final_st = spc_pkg::ST_MISMATCH;
        end
        else
        begin
            final_st = spc_pkg::ST_OK;
        end

        waddr_full = WW'(base_next) + WW'(cnt_reg);

        ctl.page_we = byte_valid && (rej_now == spc_pkg::ST_OK)
                      && (WW'(cnt_reg) < WW'(want));
        ctl.commit  = byte_valid && last_byte && (final_st == spc_pkg::ST_OK);
        ctl.status  = final_st;
        page_waddr  = PAW'(waddr_full);
        rec_base    = base_next;
        rec_size    = len_next;

        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        rej_next = rej_reg;
        if (byte_valid)
        begin
            if (last_byte)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
                rej_next = spc_pkg::ST_OK;
            end
            else
            begin
                cnt_next = cnt_inc;
                ovf_next = ovf_inc;
                rej_next = rej_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            rej_reg <= spc_pkg::ST_OK;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            rej_reg <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid)
        begin
            base_reg <= base_next;
            len_reg  <= len_next;
        end
    end

endmodule

>>> rtl/slotted_page_store_core.sv
// ----------------------------------------------------------------------------
// slotted_page_store_core
// Slotted page: records grow down from the page end, slot directory of
// offset and size pairs grows up behind a 6-byte header.
// ----------------------------------------------------------------------------
// A full record of N bytes takes N insert byte items. A read with a bad slot id
// answers in the next cycle, a read whose index lies beyond the record answers
// after the registered read of the slot directory memory, and any other read
// answers after the registered reads of the slot directory memory and then the
// page memory.
// Items are taken one at a time, and a new item also waits while an unread
// result holds the output register.
// Memory contents are undefined after reset and need no clearing pass.
module slotted_page_store_core #(
    parameter int PAGE_BYTES = spc_pkg::PAGE_BYTES_DEF,
    parameter int SLOT_LIMIT = spc_pkg::SLOT_LIMIT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  spc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output spc_pkg::rsp_t rsp
);

    localparam int PAW = $clog2(PAGE_BYTES);
    localparam int PW  = $clog2(PAGE_BYTES + 1);
    localparam int SAW = $clog2(SLOT_LIMIT);
    localparam int SCW = $clog2(SLOT_LIMIT + 1);
    localparam int DW  = $clog2(spc_pkg::HEADER_BYTES
                                + spc_pkg::SLOT_ENTRY_BYTES * SLOT_LIMIT + 1);
    localparam int CMPW = ((SCW > 10) ? SCW : 10) + 1;
    localparam int RW   = ((PW > 12) ? PW : 12) + 1;
    localparam int SEW  = PAW + PW;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_RD_SLOT = 3'b010,
        S_RD_PAGE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [SCW-1:0]    slot_total_reg, slot_total_next;
    logic [PW-1:0]     free_reg, free_next;
    logic [DW-1:0]     dir_end_reg, dir_end_next;
    logic              rsp_valid_reg, rsp_valid_next;
    spc_pkg::rsp_t     rsp_reg, rsp_next;
    spc_pkg::index_t   bidx_reg;
    logic [PW-1:0]     size_reg, size_next;

    logic              req_acc;
    logic              ins_valid;
    logic              rd_acc;
    logic              bad_slot;
    logic              page_re;
    logic [PAW-1:0]    page_raddr;
    logic [7:0]        page_rdata;
    logic [SEW-1:0]    slot_rdata;
    logic [PAW-1:0]    rd_off;
    logic [PW-1:0]     rd_size;
    logic [RW-1:0]     rd_addr_full;

    spc_pkg::ins_ctl_t ins_ctl;
    logic [PAW-1:0]    ins_waddr;
    logic [PAW-1:0]    ins_base;
    logic [PW-1:0]     ins_size;

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_acc   = req_valid && req_ready;
    assign ins_valid = req_acc && (req.action == spc_pkg::ACT_INSERT);
    assign rd_acc    = req_acc && (req.action == spc_pkg::ACT_READ);
    assign bad_slot  = CMPW'(req.slot_id) >= CMPW'(slot_total_reg);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    spc_insert #(
        .PAGE_BYTES (PAGE_BYTES),
        .SLOT_LIMIT (SLOT_LIMIT)
    ) u_insert (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (ins_valid),
        .rec_len    (req.record_length),
        .last_byte  (req.last_byte),
        .slot_total (slot_total_reg),
        .free_ptr   (free_reg),
        .dir_end    (dir_end_reg),
        .ctl        (ins_ctl),
        .page_waddr (ins_waddr),
        .rec_base   (ins_base),
        .rec_size   (ins_size)
    );

    spc_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_BYTES)
    ) u_page_ram (
        .clk   (clk),
        .we    (ins_ctl.page_we),
        .waddr (ins_waddr),
        .wdata (req.data_byte),
        .re    (page_re),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    spc_ram #(
        .WIDTH (SEW),
        .DEPTH (SLOT_LIMIT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ins_ctl.commit),
        .waddr (SAW'(slot_total_reg)),
        .wdata ({ins_base, ins_size}),
        .re    (rd_acc && !bad_slot),
        .raddr (SAW'(req.slot_id)),
        .rdata (slot_rdata)
    );

    always_comb
    begin
        rd_off       = slot_rdata[SEW-1:PW];
        rd_size      = slot_rdata[PW-1:0];
        rd_addr_full = RW'(rd_off) + RW'(bidx_reg);
        page_raddr   = PAW'(rd_addr_full);
    end

    always_comb
    begin
        state_next      = state_reg;
        slot_total_next = slot_total_reg;
        free_next       = free_reg;
        dir_end_next    = dir_end_reg;
        rsp_next        = rsp_reg;
        size_next       = size_reg;
        page_re         = 1'b0;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (ins_valid && req.last_byte)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = ins_ctl.status;
                    rsp_next.read_byte   = '0;
                    rsp_next.record_size = '0;
                    rsp_next.new_slot    = '0;
                    rsp_next.slots_used  = spc_pkg::used_t'(slot_total_reg);
                    rsp_next.free_offset = spc_pkg::length_t'(free_reg);
                    if (ins_ctl.commit)
                    begin
                        slot_total_next      = slot_total_reg + 1'b1;
                        free_next            = PW'(ins_base);
                        dir_end_next         = dir_end_reg
                                               + DW'(spc_pkg::SLOT_ENTRY_BYTES);
                        rsp_next.record_size = spc_pkg::length_t'(ins_size);
                        rsp_next.new_slot    = spc_pkg::slot_t'(slot_total_reg);
                        rsp_next.slots_used  = spc_pkg::used_t'(slot_total_next);
                        rsp_next.free_offset = spc_pkg::length_t'(free_next);
                    end
                end
                else if (rd_acc)
                begin
                    if (bad_slot)
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.status      = spc_pkg::ST_BAD_SLOT;
                        rsp_next.read_byte   = '0;
                        rsp_next.record_size = '0;
                        rsp_next.new_slot    = '0;
                        rsp_next.slots_used  = spc_pkg::used_t'(slot_total_reg);
                        rsp_next.free_offset = spc_pkg::length_t'(free_reg);
                    end
                    else
                    begin
                        state_next = S_RD_SLOT;
                    end
                end
            end

            S_RD_SLOT:
            begin
                rsp_next.read_byte   = '0;
                rsp_next.record_size = spc_pkg::length_t'(rd_size);
                rsp_next.new_slot    = '0;
                rsp_next.slots_used  = spc_pkg::used_t'(slot_total_reg);
                rsp_next.free_offset = spc_pkg::length_t'(free_reg);
                if (RW'(bidx_reg) >= RW'(rd_size))
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = spc_pkg::ST_BEYOND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    page_re    = 1'b1;
                    size_next  = rd_size;
                    state_next = S_RD_PAGE;
                end
            end

            S_RD_PAGE:
            begin
                rsp_valid_next       = 1'b1;
                rsp_next.status      = spc_pkg::ST_OK;
                rsp_next.read_byte   = page_rdata;
                rsp_next.record_size = spc_pkg::length_t'(size_reg);
                state_next           = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_total_reg <= '0;
            free_reg       <= PW'(PAGE_BYTES);
            dir_end_reg    <= DW'(spc_pkg::HEADER_BYTES);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_total_reg <= slot_total_next;
            free_reg       <= free_next;
            dir_end_reg    <= dir_end_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        size_reg <= size_next;
        if (rd_acc)
        begin
            bidx_reg <= req.byte_index;
        end
    end

endmodule

>>> rtl/spc_checker.sv
// ----------------------------------------------------------------------------
// spc_checker
// Port-level assertions for the slotted page store, bound to the top level.
// ----------------------------------------------------------------------------
module spc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input spc_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input spc_pkg::rsp_t rsp
);

    // a result waits until it is taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before it was taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("stalled result changed");

    // the closing byte of an insert run reports in the next cycle
    a_last_reports: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.action == spc_pkg::ACT_INSERT && req.last_byte
        |=> rsp_valid)
        else $error("last insert byte gave no result");

    a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != spc_pkg::ST_OK |-> rsp.read_byte == '0 && rsp.new_slot == '0)
        else $error("error result carries data");

    a_bad_slot_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == spc_pkg::ST_BAD_SLOT || rsp.status == spc_pkg::ST_NO_SPACE
                      || rsp.status == spc_pkg::ST_EMPTY || rsp.status == spc_pkg::ST_MISMATCH)
        |-> rsp.record_size == '0)
        else $error("failed item reports a record size");

endmodule

bind slotted_page_store_core spc_checker u_spc_checker (.*);

>>> sim/slotted_page_store_core_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slotted_page_store_core_chk
// Watches both channels of the slotted page store, keeps its own copy of the
// page, slot directory and insert run state, and compares every result item
// field by field with the oldest predicted answer.
// ----------------------------------------------------------------------------
module slotted_page_store_core_chk #(
    parameter int PAGE_BYTES = spc_pkg::PAGE_BYTES_DEF,
    parameter int SLOT_LIMIT = spc_pkg::SLOT_LIMIT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  spc_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  spc_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending_count,
    output int            slot_count,
    output int            free_now
);
    import spc_pkg::*;

    byte_t       page_mem [PAGE_BYTES];
    int unsigned rec_off  [SLOT_LIMIT];
    int unsigned rec_len  [SLOT_LIMIT];
    int unsigned n_slots;
    int unsigned free_ptr;
    int unsigned dir_end;
    int unsigned run_count;
    int unsigned run_base;
    status_t     run_status;
    bit          run_overflow;

    rsp_t        pending_answers [$];
    rsp_t        oldest;
    int unsigned want;
    int unsigned addr;
    int          errs;
    int          mismatches;

    function automatic rsp_t answer(status_t st, byte_t rd, int unsigned size,
                                    int unsigned slot);
        rsp_t a;
        a.status      = st;
        a.read_byte   = rd;
        a.record_size = length_t'(size);
        a.new_slot    = slot_t'(slot);
        a.slots_used  = used_t'(n_slots);
        a.free_offset = length_t'(free_ptr);
        return a;
    endfunction

    function automatic void queue_answer(rsp_t a);
        pending_answers = {pending_answers, a};
    endfunction

    function automatic int field_bad(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_slots      = 0;
            free_ptr     = PAGE_BYTES;
            dir_end      = HEADER_BYTES;
            run_count    = 0;
            run_base     = 0;
            run_status   = ST_OK;
            run_overflow = 1'b0;
            mismatches   = 0;
            pending_answers.delete();
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                if (req.action == ACT_READ)
                begin
                    if (req.slot_id >= n_slots || req.slot_id >= SLOT_LIMIT)
                        queue_answer(answer(ST_BAD_SLOT, 8'd0, 0, 0));
                    else if (req.byte_index >= rec_len[req.slot_id])
                        queue_answer(answer(ST_BEYOND, 8'd0, rec_len[req.slot_id], 0));
                    else
                    begin
                        addr = rec_off[req.slot_id] + req.byte_index;
                        queue_answer(answer(ST_OK,
                            (addr < PAGE_BYTES) ? page_mem[addr] : 8'd0,
                            rec_len[req.slot_id], 0));
                    end
                end
                else
                begin
                    // space and length are decided on the first byte of a run only
                    if (run_count == 0 && !run_overflow)
                    begin
                        run_status = ST_OK;
                        if (req.record_length == 0)
                            run_status = ST_EMPTY;
                        else if (n_slots >= SLOT_LIMIT ||
                                 free_ptr < dir_end + req.record_length + SLOT_ENTRY_BYTES)
                            run_status = ST_NO_SPACE;
                        else
                            run_base = free_ptr - req.record_length;
                    end
                    want = (run_status == ST_OK) ? free_ptr - run_base : 0;
                    // bytes land below the free pointer, out of reach of any read
                    if (run_status == ST_OK && run_count < want)
                    begin
                        addr = run_base + run_count;
                        if (addr < PAGE_BYTES)
                            page_mem[addr] = req.data_byte;
                    end
                    if (run_count >= COUNT_MAX)
                        run_overflow = 1'b1;
                    else
                        run_count++;
                    if (req.last_byte)
                    begin
                        if (run_status == ST_OK && (run_overflow || run_count != want))
                            run_status = ST_MISMATCH;
                        if (run_status != ST_OK)
                            queue_answer(answer(run_status, 8'd0, 0, 0));
                        else
                        begin
                            rec_off[n_slots] = run_base;
                            rec_len[n_slots] = want;
                            n_slots++;
                            free_ptr = run_base;
                            dir_end += SLOT_ENTRY_BYTES;
                            queue_answer(answer(ST_OK, 8'd0, want, n_slots - 1));
                        end
                        run_count    = 0;
                        run_status   = ST_OK;
                        run_overflow = 1'b0;
                    end
                end
            end

            if (rsp_valid && rsp_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("result item with nothing expected: status %0d", rsp.status);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_answers.pop_front();
                    errs = field_bad("status", oldest.status, rsp.status)
                         + field_bad("read_byte", oldest.read_byte, rsp.read_byte)
                         + field_bad("record_size", oldest.record_size, rsp.record_size)
                         + field_bad("new_slot", oldest.new_slot, rsp.new_slot)
                         + field_bad("slots_used", oldest.slots_used, rsp.slots_used)
                         + field_bad("free_offset", oldest.free_offset, rsp.free_offset);
                    if (errs != 0)
                        mismatches++;
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= pending_answers.size();
        slot_count    <= n_slots;
        free_now      <= free_ptr;
    end

endmodule

>>> sim/slotted_page_store_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slotted_page_store_core_tb
// Drives insert runs and reads into the slotted page store: a directed part
// for the edge cases, then random runs and reads that fill the page, under
// three idle patterns on the request and result channels.
// ----------------------------------------------------------------------------
module slotted_page_store_core_tb;
    import spc_pkg::*;

    localparam int RUN_LIMIT   = 1_000_000;
    localparam int ITEM_TARGET = 1000;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  rsp_ready = 1'b0;
    req_t  req       = '0;
    logic  req_ready;
    logic  rsp_valid;
    rsp_t  rsp;

    int    fail_count;
    int    pending_count;
    int    slots_now;
    int    free_now;
    int    cycle_count = 0;
    int    send_idle   = 23;
    int    take_idle   = 69;
    int    items_sent  = 0;

    slotted_page_store_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    slotted_page_store_core_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .slot_count    (slots_now),
        .free_now      (free_now)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= take_idle);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_item(input req_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // unused fields of a read carry noise
    task automatic read_slot(input int sid, input int idx);
        req_t        r;
        logic [63:0] noise;
        noise        = {$urandom, $urandom};
        r            = noise[$bits(req_t)-1:0];
        r.action     = ACT_READ;
        r.slot_id    = slot_t'(sid);
        r.byte_index = index_t'(idx);
        push_item(r);
    endtask

    // length rides on the first byte only; later bytes carry a random length
    task automatic insert_run(input int len, input int n_bytes, input int read_odds);
        req_t        r;
        logic [63:0] noise;
        for (int i = 0; i < n_bytes; i++)
        begin
            if (i > 0 && read_odds > 0 && $urandom_range(read_odds - 1) == 0)
                read_slot((slots_now > 0) ? $urandom_range(slots_now - 1, 0) : 0,
                          $urandom_range(15));
            noise     = {$urandom, $urandom};
            r         = noise[$bits(req_t)-1:0];
            r.action  = ACT_INSERT;
            if (i == 0)
                r.record_length = length_t'(len);
            r.last_byte = (i == n_bytes - 1);
            push_item(r);
        end
    endtask

    initial
    begin
        int pick;
        int sid;
        int idx;
        int len;
        int room;
        int phase_end;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        read_slot(0, 0);              // empty page
        read_slot(1023, 4095);
        insert_run(0, 1, 0);          // empty record
        insert_run(8191, 1, 0);       // widest length, no space
        insert_run(4096, 2, 0);
        insert_run(3, 3, 0);
        read_slot(0, 0);
        read_slot(0, 2);
        read_slot(0, 3);              // just past the record
        read_slot(0, 4095);
        insert_run(4, 2, 0);          // short run
        insert_run(2, 4, 0);          // excess bytes
        insert_run(2, 2, 1);          // read between the two bytes
        read_slot(1, 1);
        read_slot(2, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 23 : (phase == 1) ? 69 : 0;
            take_idle = (phase == 0) ? 69 : (phase == 1) ? 23 : 0;
            phase_end = items_sent + ITEM_TARGET / 3;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    sid = (slots_now > 0 && $urandom_range(9) != 0) ?
                          $urandom_range(slots_now - 1, 0) : $urandom_range(1023);
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: idx = $urandom_range(15);
                        6:                idx = $urandom_range(511);
                        7:                idx = 4095;
                        8:                idx = $urandom_range(4095);
                        default:          idx = 0;
                    endcase
                    read_slot(sid, idx);
                end
                else if (pick < 88)
                begin
                    room = free_now - (HEADER_BYTES + SLOT_ENTRY_BYTES * slots_now)
                         - SLOT_ENTRY_BYTES;
                    if (room < 0)
                        room = 0;
                    pick = $urandom_range(19);
                    if (pick < 15)
                        len = $urandom_range(16, 1);
                    else if (pick < 18)
                        len = (room > 800) ? $urandom_range(700, 200) : $urandom_range(64, 17);
                    else if (room > 700)
                        len = $urandom_range(16, 1);
                    else
                        // one under, exactly at, or one over the free space
                        len = (room > 1) ? room - 1 + $urandom_range(2) : 1 + $urandom_range(1);
                    insert_run(len, len, 12);
                end
                else
                begin
                    case ($urandom_range(3))
                        0: insert_run(0, $urandom_range(3, 1), 0);
                        1:
                        begin
                            len = $urandom_range(16, 2);
                            insert_run(len, $urandom_range(len - 1, 1), 0);
                        end
                        2:
                        begin
                            len = $urandom_range(8, 1);
                            insert_run(len, len + $urandom_range(4, 1), 12);
                        end
                        default: insert_run($urandom_range(8191), $urandom_range(4, 1), 0);
                    endcase
                end
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> slotted_page_store_core.f
rtl/spc_pkg.sv
rtl/spc_ram.sv
rtl/spc_insert.sv
rtl/slotted_page_store_core.sv
rtl/spc_checker.sv
sim/slotted_page_store_core_chk.sv
sim/slotted_page_store_core_tb.sv
